FILE: hdl/ru_cascade_topk_selector_defines.svh
// ------------------------------------------------------------------------
// RU cascade selector assertion macros
// Shared property wrappers, clocked on clk with asynchronous reset arst_n.
// ------------------------------------------------------------------------
`ifndef RU_CASCADE_TOPK_SELECTOR_DEFINES_SVH
`define RU_CASCADE_TOPK_SELECTOR_DEFINES_SVH

// same-cycle implication
`define RUCTS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RUCTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/ructs_pkg.sv
// ------------------------------------------------------------------------
// ructs_pkg
// Types, constants and helpers of the RU cascade top-k selector.
// ------------------------------------------------------------------------
`default_nettype none

package ructs_pkg;

	localparam int NP      = 5;   // pools, 0 = 484 tones ... 4 = 26 tones
	localparam int POOL_W  = 3;
	localparam int CNT_W   = 7;   // holds a capacity up to 127
	localparam int SLOT_AW = 7;   // holds the sum of all capacities
	localparam int KEY_W   = 32;  // {penalty, index}

	localparam int CAP_RU484_DEF = 1;
	localparam int CAP_RU242_DEF = 2;
	localparam int CAP_RU106_DEF = 4;
	localparam int CAP_RU52_DEF  = 8;
	localparam int CAP_RU26_DEF  = 18;

	localparam logic [1:0] KIND_RET   = 2'd0;
	localparam logic [1:0] KIND_DRAIN = 2'd1;
	localparam logic [1:0] KIND_EMPTY = 2'd2;

	localparam logic OP_OFFER = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	localparam logic [1:0] REG_START = 2'd0;
	localparam logic [1:0] REG_END   = 2'd1;
	localparam logic [1:0] REG_GRAN  = 2'd2;

	typedef struct packed {
		logic               start;
		logic [SLOT_AW-1:0] base;
		logic [CNT_W-1:0]   len;
		logic               find_max;
	} scan_req_t;

	typedef struct packed {
		logic               done;
		logic [KEY_W-1:0]   best_key;
		logic [SLOT_AW-1:0] best_pos;
		logic [KEY_W-1:0]   last_key;
	} scan_res_t;

	typedef struct packed {
		logic               en;
		logic [SLOT_AW-1:0] addr;
		logic [KEY_W-1:0]   data;
	} slot_wr_t;

	// rate in Mbit/s times 1000, i.e. tenths times 100
	function automatic logic [17:0] rate_of(input logic [POOL_W-1:0] m);
		logic [17:0] r;
		unique case (m)
			3'd0:    r = 18'd243800;
			3'd1:    r = 18'd121900;
			3'd2:    r = 18'd47200;
			3'd3:    r = 18'd22200;
			default: r = 18'd11100;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/ru_cascade_topk_selector.sv
// Offer: a setup step, then per pool tried a timing check and compare (the check alone
//   for a pool skipped as late or of zero capacity), a scan of each full pool, a cascade
//   step per evicted entry, and an emit step for a returned entry. Ready only when idle.
// Drain: per emitted entry one scan of the remaining pool plus select and output,
//   so quadratic in pool fill; one result register feeds the output.
// Reset: all pools empty, registers back to start 0, end 256, granularity 256.
// ------------------------------------------------------------------------
// ru_cascade_topk_selector
// Five bounded RU slot pools with cascading eviction and sorted drain.
// ------------------------------------------------------------------------
`default_nettype none

module ru_cascade_topk_selector import ructs_pkg::*; #(
	parameter int CAP_RU484 = CAP_RU484_DEF,
	parameter int CAP_RU242 = CAP_RU242_DEF,
	parameter int CAP_RU106 = CAP_RU106_DEF,
	parameter int CAP_RU52  = CAP_RU52_DEF,
	parameter int CAP_RU26  = CAP_RU26_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// packet_index, penalty, data_size, arrival_time, deadline_time
	input  wire logic [111:0] s_axis_tdata,
	// operation
	input  wire logic [0:0]   s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// ru_mode, out_index, out_penalty, zero pad
	output logic      [39:0]  m_axis_tdata,
	// kind
	output logic      [1:0]   m_axis_tuser,
	output logic              m_axis_tlast,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);

	`include "ru_cascade_topk_selector_defines.svh"

	localparam int TOTAL  = CAP_RU484 + CAP_RU242 + CAP_RU106 + CAP_RU52 + CAP_RU26;
	localparam int DEPTH  = (TOTAL > 0) ? TOTAL : 1;
	localparam int RAM_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [CNT_W-1:0] CAPV [NP] = '{
		CNT_W'(CAP_RU484), CNT_W'(CAP_RU242), CNT_W'(CAP_RU106),
		CNT_W'(CAP_RU52), CNT_W'(CAP_RU26)};
	localparam logic [SLOT_AW-1:0] BASE [NP] = '{
		SLOT_AW'(0),
		SLOT_AW'(CAP_RU484),
		SLOT_AW'(CAP_RU484 + CAP_RU242),
		SLOT_AW'(CAP_RU484 + CAP_RU242 + CAP_RU106),
		SLOT_AW'(CAP_RU484 + CAP_RU242 + CAP_RU106 + CAP_RU52)};

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_PREP  = 4'd1;
	localparam logic [3:0] ST_MUL   = 4'd2;
	localparam logic [3:0] ST_CMP   = 4'd3;
	localparam logic [3:0] ST_SCAN  = 4'd4;
	localparam logic [3:0] ST_CASC  = 4'd5;
	localparam logic [3:0] ST_EMIT  = 4'd6;
	localparam logic [3:0] ST_DSEL  = 4'd7;
	localparam logic [3:0] ST_DSCAN = 4'd8;
	localparam logic [3:0] ST_DOUT  = 4'd9;

	localparam logic [POOL_W-1:0] POOL_FIRST = '0;
	localparam logic [POOL_W-1:0] POOL_LAST  = POOL_W'(NP - 1);

	logic [3:0]        state_q;
	logic [31:0]       start_q, end_q;
	logic [15:0]       gran_q;
	logic [CNT_W-1:0]  cnt_q [NP];

	logic [KEY_W-1:0]  car_key_q;
	logic [15:0]       size_q;
	logic [31:0]       arr_q, dl_q;
	logic [34:0]       need_q;
	logic [31:0]       diff_q;
	logic              tok_q;
	logic [49:0]       have_q;
	logic [POOL_W-1:0] m_q, from_q;
	logic              casc_q;
	logic              any_q;
	logic [1:0]        ekind_q;

	scan_req_t         sreq_q;
	scan_res_t         sres;
	slot_wr_t          wr_q;
	logic [SLOT_AW-1:0] rd_addr;
	logic [KEY_W-1:0]  rd_data;

	logic              out_valid_q;
	logic [1:0]        out_kind_q;
	logic [POOL_W-1:0] out_mode_q;
	logic [KEY_W-1:0]  out_key_q;
	logic              out_last_q;

	logic [31:0]       lim;
	logic              later_nz;

	assign lim = (end_q < dl_q) ? end_q : dl_q;

	always_comb begin
		later_nz = 1'b0;
		for (int j = 0; j < NP; j++) begin
			if (POOL_W'(j) > m_q && cnt_q[j] != '0) begin
				later_nz = 1'b1;
			end
		end
	end

	ructs_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH), .AW(RAM_AW)) u_ram (
		.clk   (clk),
		.we    (wr_q.en),
		.waddr (wr_q.addr[RAM_AW-1:0]),
		.wdata (wr_q.data),
		.raddr (rd_addr[RAM_AW-1:0]),
		.rdata (rd_data)
	);

	ructs_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (sreq_q),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.res     (sres)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {5'b0, out_key_q, out_mode_q};

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 32'd0;
			end_q   <= 32'd256;
			gran_q  <= 16'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START: start_q <= cfg_data;
				REG_END:   end_q   <= cfg_data;
				REG_GRAN:  gran_q  <= cfg_data[15:0];
				default:   ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			sreq_q.start <= 1'b0;
			wr_q.en      <= 1'b0;
			for (int j = 0; j < NP; j++) begin
				cnt_q[j] <= '0;
			end
		end else begin
			sreq_q.start <= 1'b0;
			wr_q.en      <= 1'b0;
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						car_key_q <= {s_axis_tdata[31:16], s_axis_tdata[15:0]};
						size_q    <= s_axis_tdata[47:32];
						arr_q     <= s_axis_tdata[79:48];
						dl_q      <= s_axis_tdata[111:80];
						from_q    <= POOL_FIRST;
						casc_q    <= 1'b0;
						any_q     <= 1'b0;
						ekind_q   <= KIND_RET;
						if (s_axis_tuser[0] == OP_DRAIN) begin
							m_q     <= POOL_FIRST;
							state_q <= ST_DSEL;
						end else begin
							m_q     <= POOL_LAST;
							state_q <= ST_PREP;
						end
					end
				end
				ST_PREP: begin
					need_q  <= {32'(size_q) * 32'(gran_q), 3'b000};
					tok_q   <= (arr_q <= start_q) && (lim >= start_q);
					diff_q  <= lim - start_q;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (CAPV[m_q] == '0 || !tok_q) begin
						if (m_q == POOL_FIRST) begin
							state_q <= ST_EMIT;
						end else begin
							m_q <= m_q - 1'b1;
						end
					end else begin
						have_q  <= diff_q * rate_of(m_q);
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (have_q >= {15'd0, need_q}) begin
						if (cnt_q[m_q] < CAPV[m_q]) begin
							wr_q.en     <= 1'b1;
							wr_q.addr   <= BASE[m_q] + SLOT_AW'(cnt_q[m_q]);
							wr_q.data   <= car_key_q;
							cnt_q[m_q]  <= cnt_q[m_q] + 1'b1;
							state_q     <= ST_IDLE;
						end else begin
							sreq_q.start    <= 1'b1;
							sreq_q.base     <= BASE[m_q];
							sreq_q.len      <= CAPV[m_q];
							sreq_q.find_max <= 1'b0;
							state_q         <= ST_SCAN;
						end
					end else if (m_q == POOL_FIRST) begin
						state_q <= ST_EMIT;
					end else begin
						m_q     <= m_q - 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_SCAN: begin
					if (sres.done) begin
						// evict only on a strictly lower penalty
						if (sres.best_key[31:16] < car_key_q[31:16]) begin
							wr_q.en   <= 1'b1;
							wr_q.addr <= sres.best_pos;
							wr_q.data <= car_key_q;
							car_key_q <= sres.best_key;
							from_q    <= m_q;
							casc_q    <= 1'b1;
							if (m_q == POOL_FIRST) begin
								state_q <= ST_EMIT;
							end else begin
								m_q     <= m_q - 1'b1;
								state_q <= ST_CASC;
							end
						end else if (casc_q || m_q == POOL_FIRST) begin
							state_q <= ST_EMIT;
						end else begin
							m_q     <= m_q - 1'b1;
							state_q <= ST_MUL;
						end
					end
				end
				ST_CASC: begin
					if (CAPV[m_q] == '0) begin
						state_q <= ST_EMIT;
					end else if (cnt_q[m_q] < CAPV[m_q]) begin
						wr_q.en    <= 1'b1;
						wr_q.addr  <= BASE[m_q] + SLOT_AW'(cnt_q[m_q]);
						wr_q.data  <= car_key_q;
						cnt_q[m_q] <= cnt_q[m_q] + 1'b1;
						state_q    <= ST_IDLE;
					end else begin
						sreq_q.start    <= 1'b1;
						sreq_q.base     <= BASE[m_q];
						sreq_q.len      <= CAPV[m_q];
						sreq_q.find_max <= 1'b0;
						state_q         <= ST_SCAN;
					end
				end
				ST_EMIT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= ekind_q;
						out_mode_q  <= from_q;
						out_key_q   <= car_key_q;
						out_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_DSEL: begin
					if (cnt_q[m_q] == '0) begin
						if (m_q != POOL_LAST) begin
							m_q <= m_q + 1'b1;
						end else if (any_q) begin
							state_q <= ST_IDLE;
						end else begin
							ekind_q   <= KIND_EMPTY;
							car_key_q <= '0;
							from_q    <= POOL_FIRST;
							state_q   <= ST_EMIT;
						end
					end else begin
						any_q           <= 1'b1;
						sreq_q.start    <= 1'b1;
						sreq_q.base     <= BASE[m_q];
						sreq_q.len      <= cnt_q[m_q];
						sreq_q.find_max <= 1'b1;
						state_q         <= ST_DSCAN;
					end
				end
				ST_DSCAN: begin
					if (sres.done) begin
						state_q <= ST_DOUT;
					end
				end
				ST_DOUT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= KIND_DRAIN;
						out_mode_q  <= m_q;
						out_key_q   <= sres.best_key;
						out_last_q  <= (cnt_q[m_q] == CNT_W'(1)) && !later_nz;
						// move the pool's last entry into the emitted slot
						wr_q.en     <= 1'b1;
						wr_q.addr   <= sres.best_pos;
						wr_q.data   <= sres.last_key;
						cnt_q[m_q]  <= cnt_q[m_q] - 1'b1;
						state_q     <= ST_DSEL;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`RUCTS_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "accepted item left the block ready")
	`RUCTS_ASSERT_NOW(a_scan_owner, sres.done, state_q == ST_SCAN || state_q == ST_DSCAN, "scan finished outside a scan state")
	`RUCTS_ASSERT_NOW(a_pool_bound, 1'b1, cnt_q[NP-1] <= CAPV[NP-1] && cnt_q[0] <= CAPV[0], "pool count over capacity")
	`RUCTS_ASSERT_NEXT(a_out_hold, out_valid_q && !m_axis_tready, out_valid_q && $stable(m_axis_tdata), "stalled result dropped or changed")

endmodule

`default_nettype wire

FILE: hdl/ructs_ram.sv
// ------------------------------------------------------------------------
// ructs_ram
// Generic single-write, single-read RAM with registered read data.
// ------------------------------------------------------------------------
`default_nettype none

module ructs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 33,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: hdl/ructs_scan.sv
// ------------------------------------------------------------------------
// ructs_scan
// Walks a slot range one read a cycle and keeps its minimum or maximum key.
// ------------------------------------------------------------------------
`default_nettype none

module ructs_scan import ructs_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire scan_req_t          req,
	output logic      [SLOT_AW-1:0] rd_addr,
	input  wire logic [KEY_W-1:0]   rd_data,
	output scan_res_t               res
);

	logic               busy_q;
	logic [SLOT_AW-1:0] pos_q;
	logic [CNT_W-1:0]   rem_q;
	logic               max_q;
	logic               first_q;
	logic               pend_s1;
	logic [SLOT_AW-1:0] pend_pos_s1;
	logic               done_q;
	logic [KEY_W-1:0]   best_key_q;
	logic [SLOT_AW-1:0] best_pos_q;
	logic [KEY_W-1:0]   last_key_q;
	logic               better;
	logic               issue;

	assign rd_addr = pos_q;
	assign issue   = busy_q && (rem_q != '0);

	always_comb begin
		if (first_q) begin
			better = 1'b1;
		end else if (max_q) begin
			better = rd_data > best_key_q;
		end else begin
			better = rd_data < best_key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			pend_s1 <= 1'b0;
			done_q  <= 1'b0;
			first_q <= 1'b0;
		end else begin
			done_q  <= 1'b0;
			pend_s1 <= issue;
			if (req.start) begin
				busy_q  <= 1'b1;
				first_q <= 1'b1;
			end else if (pend_s1) begin
				first_q <= 1'b0;
				if (rem_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			pos_q <= req.base;
			rem_q <= req.len;
			max_q <= req.find_max;
		end else if (issue) begin
			pos_q <= pos_q + 1'b1;
			rem_q <= rem_q - 1'b1;
		end
		pend_pos_s1 <= pos_q;
		if (pend_s1) begin
			last_key_q <= rd_data;
			if (better) begin
				best_key_q <= rd_data;
				best_pos_q <= pend_pos_s1;
			end
		end
	end

	assign res.done     = done_q;
	assign res.best_key = best_key_q;
	assign res.best_pos = best_pos_q;
	assign res.last_key = last_key_q;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RU cascade top-k selector: directed table of
// offers and drains, then random traffic, all checked against a predictor.
// ------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import ructs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPS [NP] = '{CAP_RU484_DEF, CAP_RU242_DEF, CAP_RU106_DEF,
		CAP_RU52_DEF, CAP_RU26_DEF};
	localparam int BASES [NP] = '{0, 1, 3, 7, 15};
	localparam int NSLOT = 33;
	localparam int NRAND = 370;
	localparam logic [63:0] RATES [NP] = '{64'd2438, 64'd1219, 64'd472, 64'd222, 64'd111};

	typedef struct packed {
		logic        op;
		logic [15:0] idx;
		logic [15:0] pen;
		logic [15:0] size;
		logic [31:0] arr;
		logic [31:0] dl;
	} pkt_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  mode;
		logic [15:0] idx;
		logic [15:0] pen;
		logic        last;
	} res_t;

	typedef struct {
		pkt_t p;
		logic has_exp;
		res_t r;
	} row_t;

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready;
	logic [111:0] s_axis_tdata;
	logic [0:0] s_axis_tuser;
	logic m_axis_tvalid, m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic m_axis_tlast;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	ru_cascade_topk_selector i_dut (.*);

	// predictor state
	logic [31:0] pr_start, pr_end;
	logic [15:0] pr_gran;
	logic [15:0] sl_pen [NSLOT];
	logic [15:0] sl_idx [NSLOT];
	int pool_fill [NP];

	res_t exp_results [$];
	int errors;
	bit stim_done;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("ru_cascade_topk_selector: mismatch");
		$finish;
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
		errors++;
	endtask

	function automatic bit fits(int m, pkt_t p);
		logic [31:0] lim;
		logic [63:0] need, have;
		if (p.arr > pr_start) return 0;
		lim = (pr_end < p.dl) ? pr_end : p.dl;
		if (lim < pr_start) return 0;
		need = 64'(p.size) * 64'(pr_gran) * 64'd8;
		have = 64'(lim - pr_start) * RATES[m] * 64'd100;
		return have >= need;
	endfunction

	function automatic int min_slot(int m);
		int b, j;
		b = BASES[m];
		for (int i = 1; i < pool_fill[m]; i++) begin
			j = BASES[m] + i;
			if (sl_pen[j] < sl_pen[b] || (sl_pen[j] == sl_pen[b] && sl_idx[j] < sl_idx[b]))
				b = j;
		end
		return b;
	endfunction

	function automatic void place(int m, logic [15:0] pen, logic [15:0] idx);
		sl_pen[BASES[m] + pool_fill[m]] = pen;
		sl_idx[BASES[m] + pool_fill[m]] = idx;
		pool_fill[m]++;
	endfunction

	task automatic predict_offer(input pkt_t p);
		int k, from, c;
		logic [15:0] cp, ci, tp, ti;
		res_t r;
		for (int m = NP - 1; m >= 0; m--) begin
			if (CAPS[m] == 0 || !fits(m, p)) continue;
			if (pool_fill[m] < CAPS[m]) begin
				place(m, p.pen, p.idx);
				return;
			end
			k = min_slot(m);
			if (sl_pen[k] >= p.pen) continue;
			cp = sl_pen[k]; ci = sl_idx[k];
			sl_pen[k] = p.pen; sl_idx[k] = p.idx;
			from = m; c = m;
			while (c > 0) begin
				c--;
				if (CAPS[c] == 0) break;
				if (pool_fill[c] < CAPS[c]) begin
					place(c, cp, ci);
					return;
				end
				k = min_slot(c);
				if (sl_pen[k] < cp) begin
					tp = sl_pen[k]; ti = sl_idx[k];
					sl_pen[k] = cp; sl_idx[k] = ci;
					cp = tp; ci = ti; from = c;
				end else break;
			end
			r = '{kind: KIND_RET, mode: 3'(from), idx: ci, pen: cp, last: 1'b1};
			exp_results.insert(exp_results.size(), r);
			return;
		end
		r = '{kind: KIND_RET, mode: 3'd0, idx: p.idx, pen: p.pen, last: 1'b1};
		exp_results.insert(exp_results.size(), r);
	endtask

	task automatic predict_drain();
		logic [31:0] keys [$];
		int n;
		res_t r;
		n = 0;
		for (int m = 0; m < NP; m++) begin
			keys.delete();
			for (int i = 0; i < pool_fill[m]; i++)
				keys.insert(keys.size(), {sl_pen[BASES[m] + i], sl_idx[BASES[m] + i]});
			keys.rsort();
			foreach (keys[i]) begin
				r = '{kind: KIND_DRAIN, mode: 3'(m), idx: keys[i][15:0],
					pen: keys[i][31:16], last: 1'b0};
				exp_results.insert(exp_results.size(), r);
				n++;
			end
			pool_fill[m] = 0;
		end
		if (n == 0) begin
			r = '{kind: KIND_EMPTY, mode: 3'd0, idx: 16'd0, pen: 16'd0, last: 1'b1};
			exp_results.insert(exp_results.size(), r);
		end else
			exp_results[$].last = 1'b1;
	endtask

	task automatic predict(input pkt_t p);
		if (p.op == OP_DRAIN) predict_drain();
		else predict_offer(p);
	endtask

	// valid stays up after a transfer until the next idle gap or quiesce
	task automatic send(input pkt_t p);
		int gap;
		gap = $urandom_range(0, 19);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= p.op;
		s_axis_tdata <= {p.dl, p.arr, p.size, p.pen, p.idx};
		do @(posedge clk); while (!s_axis_tready);
		predict(p);
	endtask

	task automatic quiesce();
		int guard;
		guard = 0;
		s_axis_tvalid <= 1'b0;
		while (exp_results.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] ix, input logic [31:0] v);
		cfg_we <= 1'b1; cfg_index <= ix; cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (ix)
			REG_START: pr_start = v;
			REG_END:   pr_end = v;
			default:   pr_gran = v[15:0];
		endcase
	endtask

	// receiver with random backpressure
	initial begin
		res_t got, want;
		int wait_n;
		m_axis_tready = 1'b0;
		wait_n = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{kind: m_axis_tuser, mode: m_axis_tdata[2:0],
					idx: m_axis_tdata[18:3], pen: m_axis_tdata[34:19], last: m_axis_tlast};
				if (exp_results.size() == 0) report("unexpected result", 32'(got.idx), 32'd0);
				else begin
					want = exp_results.pop_front();
					if (got.kind != want.kind)
						report("kind", 32'(got.kind), 32'(want.kind));
					if (got.mode != want.mode)
						report("ru_mode", 32'(got.mode), 32'(want.mode));
					if (got.idx != want.idx)
						report("out_index", 32'(got.idx), 32'(want.idx));
					if (got.pen != want.pen)
						report("out_penalty", 32'(got.pen), 32'(want.pen));
					if (got.last != want.last)
						report("last", 32'(got.last), 32'(want.last));
				end
				wait_n = stim_done ? 0 : $urandom_range(0, 19);
				if ($urandom_range(0, 3) == 0) wait_n = 0;
			end
			if (wait_n > 0) begin
				m_axis_tready <= 1'b0;
				wait_n--;
			end else
				m_axis_tready <= 1'b1;
		end
	end

	function automatic pkt_t offer(logic [15:0] i, logic [15:0] pn, logic [15:0] sz,
		logic [31:0] a, logic [31:0] d);
		return '{op: OP_OFFER, idx: i, pen: pn, size: sz, arr: a, dl: d};
	endfunction

	function automatic pkt_t rand_pkt();
		pkt_t p;
		p.op = ($urandom_range(0, 29) == 0) ? OP_DRAIN : OP_OFFER;
		p.idx = 16'($urandom);
		p.pen = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
		case ($urandom_range(0, 3))
			0: p.size = 16'($urandom);
			1: p.size = 16'($urandom_range(0, 4000));
			default: p.size = 16'($urandom_range(0, 200));
		endcase
		p.arr = ($urandom_range(0, 9) == 0) ? $urandom : pr_start - 32'($urandom_range(0, 50));
		if (p.arr > pr_start) p.arr = ($urandom_range(0, 1) == 0) ? p.arr : 32'd0;
		p.dl = ($urandom_range(0, 9) == 0) ? $urandom : pr_start + 32'($urandom_range(0, 600));
		return p;
	endfunction

	initial begin
		row_t rows [$];
		pkt_t dr;
		res_t r;
		logic [31:0] starts [4] = '{32'd0, 32'd1000, 32'hFFFF_FF00, 32'd50};
		logic [31:0] ends [4] = '{32'd256, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0};
		logic [31:0] grans [4] = '{32'd256, 32'd1, 32'd65535, 32'd2};

		errors = 0; stim_done = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		pr_start = 0; pr_end = 256; pr_gran = 256;
		foreach (pool_fill[m]) pool_fill[m] = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		dr = '{op: OP_DRAIN, default: '0};
		// empty drain after reset
		rows.insert(rows.size(), '{dr, 1'b1, '{KIND_EMPTY, 3'd0, 16'd0, 16'd0, 1'b1}});
		// late arrival: returned unplaced
		rows.insert(rows.size(),
			'{offer(16'hFFFF, 16'hFFFF, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
			1'b1, '{KIND_RET, 3'd0, 16'hFFFF, 16'hFFFF, 1'b1}});
		// too large for any RU
		rows.insert(rows.size(), '{offer(16'd7, 16'd9, 16'hFFFF, 32'd0, 32'd256),
			1'b1, '{KIND_RET, 3'd0, 16'd7, 16'd9, 1'b1}});
		// deadline at start, zero size: still placed
		rows.insert(rows.size(), '{offer(16'd1, 16'd1, 16'd0, 32'd0, 32'd0), 1'b0, r});
		// fill the 26-tone pool, then higher penalties evict its lowest, which cascade
		for (int i = 0; i < 20; i++)
			rows.insert(rows.size(),
				'{offer(16'(i), 16'(i % 5), 16'(i * 3), 32'd0, 32'd256), 1'b0, r});
		rows.insert(rows.size(),
			'{offer(16'h0000, 16'hFFFF, 16'd1, 32'd0, 32'hFFFF_FFFF), 1'b0, r});
		rows.insert(rows.size(), '{dr, 1'b0, r});

		foreach (rows[i]) begin
			if (rows[i].has_exp) begin
				send(rows[i].p);
				// the predictor's last expected result must agree with the directed value
				if (exp_results.size() == 0 || exp_results[$] != rows[i].r)
					report("directed row", 32'(i), 32'd0);
			end else
				send(rows[i].p);
		end
		quiesce();

		for (int ph = 0; ph < 4; ph++) begin
			write_reg(REG_START, starts[ph]);
			write_reg(REG_END, ends[ph]);
			write_reg(REG_GRAN, grans[ph]);
			for (int n = 0; n < NRAND / 4; n++) send(rand_pkt());
			send(dr);
			quiesce();
		end
		stim_done = 1;
		quiesce();
		if (errors == 0 && exp_results.size() == 0)
			$display("ru_cascade_topk_selector: match");
		else
			$display("ru_cascade_topk_selector: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
